### hw/rtl/dda_pkg.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer package
// Shared types and fixed constants for the line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COLOR_W = 24;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 24'h00FF00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_EMIT
    } dda_state_t;

endpackage

### hw/rtl/dda_div.sv
// ----------------------------------------------------------------------------
// DDA increment divider
// Restoring divider that forms (dividend << FRAC_BITS) / divisor, one quotient
// bit per cycle, for a dividend that never exceeds the divisor.
// ----------------------------------------------------------------------------
module dda_div #(
    parameter int COORD_BITS = 6,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] dividend,
    input  logic [COORD_BITS-1:0] divisor,
    output logic                  done,
    output logic [FRAC_BITS:0]    quotient
);

    localparam int ITERS = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(ITERS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COORD_BITS:0]   rem_reg, rem_next;
    logic [COORD_BITS-1:0] dvs_reg, dvs_next;
    logic [FRAC_BITS:0]    q_reg, q_next;
    logic [COORD_BITS:0]   rem_sh;
    logic                  ge;

    // The first iteration yields the integer bit and takes the remainder as is.
    always_comb
    begin
        rem_sh = (cnt_reg == CNT_W'(ITERS)) ? rem_reg : {rem_reg[COORD_BITS-1:0], 1'b0};
        ge     = rem_sh >= {1'b0, dvs_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ITERS);
            rem_next  = {1'b0, dividend};
            dvs_next  = divisor;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            q_next   = {q_reg[FRAC_BITS-1:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### hw/rtl/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// DDA line rasterizer
// Rasterizes one line segment per input word into a stream of pixel words.
// ----------------------------------------------------------------------------
// A segment of n pixels (n is the larger of |dx| and |dy|) occupies the block
// while the shared divider forms the x and then the y increment at one quotient
// bit per cycle, and then one pixel word leaves per cycle while the output is not
// stalled. The input is stalled from acceptance until the last pixel word is
// loaded into the output register. A segment whose start equals its end emits
// nothing.
module dda_line_rasterizer #(
    parameter int COORD_BITS = 6,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dda_pkg::COLOR_W-1:0]  cfg_data,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [COORD_BITS-1:0]        start_x,
    input  logic [COORD_BITS-1:0]        start_y,
    input  logic [COORD_BITS-1:0]        end_x,
    input  logic [COORD_BITS-1:0]        end_y,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [COORD_BITS-1:0]        pixel_x,
    output logic [COORD_BITS-1:0]        pixel_y,
    output logic [dda_pkg::COLOR_W-1:0]  color_out,
    output logic                         last_pixel
);

    localparam int POS_W  = COORD_BITS + FRAC_BITS + 1;
    localparam int STEP_W = FRAC_BITS + 2;
    localparam logic [POS_W-1:0] HALF = {{(POS_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    dda_pkg::dda_state_t state_reg, state_next;

    logic [dda_pkg::COLOR_W-1:0] pixel_color_reg;

    logic signed [POS_W-1:0]  x_pos_reg, x_pos_next;
    logic signed [POS_W-1:0]  y_pos_reg, y_pos_next;
    logic signed [STEP_W-1:0] x_step_reg, x_step_next;
    logic signed [STEP_W-1:0] y_step_reg, y_step_next;
    logic [COORD_BITS-1:0]    steps_left_reg, steps_left_next;
    logic [COORD_BITS-1:0]    ady_reg, ady_next;
    logic                     x_neg_reg, x_neg_next;
    logic                     y_neg_reg, y_neg_next;

    logic                     out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0]    pixel_x_reg, pixel_x_next;
    logic [COORD_BITS-1:0]    pixel_y_reg, pixel_y_next;
    logic [dda_pkg::COLOR_W-1:0] color_reg, color_next;
    logic                     last_reg, last_next;

    logic                     in_take;
    logic                     out_load;
    logic                     dx_neg, dy_neg;
    logic [COORD_BITS-1:0]    adx, ady, steps;

    logic                     div_start;
    logic [COORD_BITS-1:0]    div_dividend;
    logic [COORD_BITS-1:0]    div_divisor;
    logic                     div_done;
    logic [FRAC_BITS:0]       div_quot;
    logic signed [STEP_W-1:0] quot_s;

    logic [POS_W-1:0]         x_rnd, y_rnd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_color_reg <= dda_pkg::COLOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pixel_color_reg <= cfg_data;
        end
    end

    always_comb
    begin
        dx_neg = end_x < start_x;
        dy_neg = end_y < start_y;
        adx    = dx_neg ? (start_x - end_x) : (end_x - start_x);
        ady    = dy_neg ? (start_y - end_y) : (end_y - start_y);
        steps  = (adx > ady) ? adx : ady;
    end

    assign in_stall = (state_reg != dda_pkg::ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_load = (state_reg == dda_pkg::ST_EMIT) && (!out_valid_reg || !out_stall);

    assign div_start    = (in_take && (steps != '0))
                          || ((state_reg == dda_pkg::ST_DIV_X) && div_done);
    assign div_dividend = (state_reg == dda_pkg::ST_IDLE) ? adx : ady_reg;
    assign div_divisor  = (state_reg == dda_pkg::ST_IDLE) ? steps : steps_left_reg;

    dda_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign quot_s = $signed({1'b0, div_quot});

    // Positions never leave the tile, but negative values still clamp to zero.
    always_comb
    begin
        x_rnd = x_pos_reg[POS_W-1] ? '0 : ($unsigned(x_pos_reg) + HALF);
        y_rnd = y_pos_reg[POS_W-1] ? '0 : ($unsigned(y_pos_reg) + HALF);
    end

    always_comb
    begin
        state_next      = state_reg;
        x_pos_next      = x_pos_reg;
        y_pos_next      = y_pos_reg;
        x_step_next     = x_step_reg;
        y_step_next     = y_step_reg;
        steps_left_next = steps_left_reg;
        ady_next        = ady_reg;
        x_neg_next      = x_neg_reg;
        y_neg_next      = y_neg_reg;
        out_valid_next  = out_valid_reg && out_stall;
        pixel_x_next    = pixel_x_reg;
        pixel_y_next    = pixel_y_reg;
        color_next      = color_reg;
        last_next       = last_reg;

        unique case (state_reg)
            dda_pkg::ST_IDLE:
            begin
                if (in_take && (steps != '0))
                begin
                    x_pos_next      = $signed({1'b0, start_x, {FRAC_BITS{1'b0}}});
                    y_pos_next      = $signed({1'b0, start_y, {FRAC_BITS{1'b0}}});
                    steps_left_next = steps;
                    ady_next        = ady;
                    x_neg_next      = dx_neg;
                    y_neg_next      = dy_neg;
                    state_next      = dda_pkg::ST_DIV_X;
                end
            end
            dda_pkg::ST_DIV_X:
            begin
                if (div_done)
                begin
                    x_step_next = x_neg_reg ? -quot_s : quot_s;
                    state_next  = dda_pkg::ST_DIV_Y;
                end
            end
            dda_pkg::ST_DIV_Y:
            begin
                if (div_done)
                begin
                    y_step_next = y_neg_reg ? -quot_s : quot_s;
                    state_next  = dda_pkg::ST_EMIT;
                end
            end
            dda_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    pixel_x_next    = x_rnd[FRAC_BITS +: COORD_BITS];
                    pixel_y_next    = y_rnd[FRAC_BITS +: COORD_BITS];
                    color_next      = pixel_color_reg;
                    last_next       = (steps_left_reg == COORD_BITS'(1));
                    x_pos_next      = x_pos_reg + POS_W'(x_step_reg);
                    y_pos_next      = y_pos_reg + POS_W'(y_step_reg);
                    steps_left_next = steps_left_reg - COORD_BITS'(1);
                    if (steps_left_reg == COORD_BITS'(1))
                    begin
                        state_next = dda_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = dda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dda_pkg::ST_IDLE;
            steps_left_reg <= '0;
            out_valid_reg  <= 1'b0;
            x_pos_reg      <= '0;
            y_pos_reg      <= '0;
            x_step_reg     <= '0;
            y_step_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            steps_left_reg <= steps_left_next;
            out_valid_reg  <= out_valid_next;
            x_pos_reg      <= x_pos_next;
            y_pos_reg      <= y_pos_next;
            x_step_reg     <= x_step_next;
            y_step_reg     <= y_step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ady_reg     <= ady_next;
        x_neg_reg   <= x_neg_next;
        y_neg_reg   <= y_neg_next;
        pixel_x_reg <= pixel_x_next;
        pixel_y_reg <= pixel_y_next;
        color_reg   <= color_next;
        last_reg    <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign color_out  = color_reg;
    assign last_pixel = last_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == dda_pkg::ST_DIV_X || state_reg == dda_pkg::ST_DIV_Y))
        else $error("Divider finished outside an increment phase.");

    a_emit_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dda_pkg::ST_EMIT) |-> (steps_left_reg != '0))
        else $error("Pixel emission with no steps left.");

    a_segment_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (steps != '0)) |=> (state_reg == dda_pkg::ST_DIV_X))
        else $error("Accepted segment did not start the divider.");

    a_last_ends_segment: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (steps_left_reg == COORD_BITS'(1)))
        |=> (state_reg == dda_pkg::ST_IDLE && last_reg && out_valid_reg))
        else $error("Last pixel word did not close the segment.");

endmodule

### dv/tb_dda_line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DDA line rasterizer testbench
// Drives line segments through the rasterizer under several idle and stall
// mixes and color settings. An in-bench DDA model predicts every pixel word,
// and a scoreboard checks each output word in order against the prediction.
// ----------------------------------------------------------------------------
module tb_dda_line_rasterizer;

    localparam int COORD_BITS = 6;
    localparam int FRAC_BITS  = 16;
    localparam int CLK_HALF   = 6;
    localparam int DRAIN_CYCLES = 2 * (FRAC_BITS + 2) + (1 << COORD_BITS) + 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PER_PHASE = 18;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [dda_pkg::COLOR_W-1:0] color_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        color_t color;
        logic   last;
    } pixel_word_t;

    class raster_scoreboard;
        pixel_word_t expected_pixels[$];
        color_t      color;
        int          errors;

        function new();
            color  = dda_pkg::COLOR_RESET;
            errors = 0;
        endfunction

        function longint frac_increment(longint delta, longint steps);
            longint mag;
            longint q;
            mag = (delta < 0) ? -delta : delta;
            q = (mag << FRAC_BITS) / steps;
            return (delta < 0) ? -q : q;
        endfunction

        function coord_t round_position(longint pos);
            longint p;
            p = (pos < 0) ? 0 : pos;
            return coord_t'((p + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
        endfunction

        function void plot_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
            longint      dx, dy, adx, ady, steps;
            longint      x_inc, y_inc, x_pos, y_pos;
            pixel_word_t w;
            dx = longint'(ex) - longint'(sx);
            dy = longint'(ey) - longint'(sy);
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            steps = (adx > ady) ? adx : ady;
            if (steps == 0)
                return;
            x_inc = frac_increment(dx, steps);
            y_inc = frac_increment(dy, steps);
            x_pos = longint'(sx) << FRAC_BITS;
            y_pos = longint'(sy) << FRAC_BITS;
            for (longint left = steps; left > 0; left--)
            begin
                w.x     = round_position(x_pos);
                w.y     = round_position(y_pos);
                w.color = color;
                w.last  = (left == 1);
                expected_pixels.push_back(w);
                x_pos += x_inc;
                y_pos += y_inc;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_pixel(coord_t x, coord_t y, color_t c, logic last);
            pixel_word_t w;
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("pixel word (%0d,%0d) with none expected", x, y));
                return;
            end
            w = expected_pixels.pop_front();
            if (x !== w.x)
                report_mismatch($sformatf("pixel_x got %0d expected %0d", x, w.x));
            if (y !== w.y)
                report_mismatch($sformatf("pixel_y got %0d expected %0d", y, w.y));
            if (c !== w.color)
                report_mismatch($sformatf("color_out got %06h expected %06h", c, w.color));
            if (last !== w.last)
                report_mismatch($sformatf("last_pixel got %0b expected %0b", last, w.last));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    color_t             cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    coord_t             start_x = '0;
    coord_t             start_y = '0;
    coord_t             end_x = '0;
    coord_t             end_y = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    coord_t             pixel_x;
    coord_t             pixel_y;
    color_t             color_out;
    logic               last_pixel;

    raster_scoreboard   sb = new();
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    logic               holding = 1'b0;
    int                 quiet_cycles = 0;
    event               start_hold;

    dda_line_rasterizer #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .color_out  (color_out),
        .last_pixel (last_pixel)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_pixel(pixel_x, pixel_y, color_out, last_pixel);
        out_stall <= holding || ($urandom_range(0, 99) < recv_stall_pct);
    end

    // The long output hold-off runs on its own so the sender keeps offering words.
    initial
    begin
        forever
        begin
            @(start_hold);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.plot_segment(sx, sy, ex, ey);
    endtask

    task send_random_segment();
        coord_t sx, sy, ex, ey;
        int     kind;
        kind = $urandom_range(0, 99);
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        ex = coord_t'($urandom);
        ey = coord_t'($urandom);
        if (kind < 15)
        begin
            ex = sx;
            ey = sy;
        end
        else if (kind < 30)
        begin
            ex = sx + coord_t'($urandom_range(0, 6) - 3);
            ey = sy + coord_t'($urandom_range(0, 6) - 3);
        end
        else if (kind < 42)
        begin
            sx = $urandom_range(0, 1) ? COORD_MAX : '0;
            sy = $urandom_range(0, 1) ? COORD_MAX : '0;
            ex = $urandom_range(0, 1) ? COORD_MAX : '0;
            ey = $urandom_range(0, 1) ? COORD_MAX : '0;
        end
        send_segment(sx, sy, ex, ey);
    endtask

    task drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task write_color(color_t c);
        cfg_data  <= c;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.color = c;
        cfg_valid <= 1'b0;
    endtask

    task run_phase(int idle_pct, int stall_pct, color_t c, bit hold);
        write_color(c);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (hold)
            -> start_hold;
        repeat (RANDOM_PER_PHASE) send_random_segment();
        drain();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed segments at the reset color, no idling.
        send_segment(0, 0, 0, 0);
        send_segment(0, 0, COORD_MAX, COORD_MAX);
        send_segment(COORD_MAX, COORD_MAX, 0, 0);
        send_segment(0, COORD_MAX, COORD_MAX, 0);
        send_segment(COORD_MAX, 0, 0, COORD_MAX);
        send_segment(0, 5, COORD_MAX, 5);
        send_segment(COORD_MAX, 5, 0, 5);
        send_segment(7, 0, 7, COORD_MAX);
        send_segment(7, COORD_MAX, 7, 0);
        send_segment(20, 20, 20, 20);
        send_segment(10, 10, 11, 10);
        send_segment(10, 10, 9, 11);
        send_segment(0, 0, 2, 1);
        send_segment(5, 5, 2, 4);
        send_segment(0, 0, COORD_MAX, 1);
        send_segment(0, 0, 1, COORD_MAX);
        send_segment(COORD_MAX, 0, 0, 31);
        send_segment(3, 60, 40, 2);
        send_segment(42, 42, 42, 42);
        send_segment(1, 2, 60, 3);
        drain();

        run_phase(0, 0, 24'hFFFFFF, 1'b0);
        run_phase(55, 0, 24'h000000, 1'b0);
        run_phase(0, 55, color_t'($urandom), 1'b1);
        run_phase(31, 31, color_t'($urandom), 1'b0);
        run_phase(0, 0, 24'hA5C30F, 1'b0);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
hw/rtl/dda_pkg.sv
hw/rtl/dda_div.sv
hw/rtl/dda_line_rasterizer.sv
dv/tb_dda_line_rasterizer.sv
